@@ rtl/core/lsc_pkg.sv @@
package lsc_pkg;

    // Widths of the request and result fields as they appear on the ports.
    localparam int MODE_W = 3;
    localparam int ROW_W  = 5;
    localparam int CODE_W = 38;
    localparam int DATA_W = 32;
    localparam int POS_W  = 7;
    localparam int SYN_W  = 6;

    // Operating modes.
    localparam logic [MODE_W-1:0] MODE_LOAD_GEN   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_CHK   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LOAD_REC   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ENCODE     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DECODE     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_ROUND_TRIP = 3'd5;

    // Row write request from the pipeline to the matrix store.
    typedef struct packed {
        logic             gen_we;
        logic             chk_we;
        logic             rec_we;
        logic [ROW_W-1:0] row;
    } load_req_t;

endpackage

@@ rtl/core/linear_sec_code_encode_decode.sv @@
// Channel | Handshake            | Moves per request
// --------+----------------------+-----------------------------------------------------
// in      | in_valid / in_ready  | mode, row_index, row_bits, data_word,
//         |                      | received_word, err_bits
// out     | out_valid / out_ready| encoded_word, corrected_word, corrected_position,
//         |                      | decoded_data, syndrome
//
// A request sits in the input register while the encode, syndrome, column match and
// recovery logic work on it. A new request is accepted every cycle unless both
// registers are full and the sink stalls; the output register holds a result while
// the sink stalls, and the input register keeps taking requests until both are full.
// Reset clears only the two valid flags; the matrix rows are undefined until loaded.
// A row load takes effect as it leaves the input register, so the next request sees it.
module linear_sec_code_encode_decode #(
    parameter int DATA_BITS   = 32,
    parameter int PARITY_BITS = 6,
    parameter int CODE_BITS   = 38
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [lsc_pkg::MODE_W-1:0]            mode,
    input  logic [lsc_pkg::ROW_W-1:0]             row_index,
    input  logic [lsc_pkg::CODE_W-1:0]            row_bits,
    input  logic [lsc_pkg::DATA_W-1:0]            data_word,
    input  logic [lsc_pkg::CODE_W-1:0]            received_word,
    input  logic [lsc_pkg::CODE_W-1:0]            err_bits,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [lsc_pkg::CODE_W-1:0]            encoded_word,
    output logic [lsc_pkg::CODE_W-1:0]            corrected_word,
    output logic signed [lsc_pkg::POS_W-1:0]      corrected_position,
    output logic [lsc_pkg::DATA_W-1:0]            decoded_data,
    output logic [lsc_pkg::SYN_W-1:0]             syndrome
);
    import lsc_pkg::*;

    // Where the configured widths exceed the port widths, the extra bits are zero;
    // where they are narrower, the upper port bits are ignored.
    localparam int CW_MIN = (CODE_BITS < CODE_W) ? CODE_BITS : CODE_W;
    localparam int DW_MIN = (DATA_BITS < DATA_W) ? DATA_BITS : DATA_W;

    // Input register.
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic [MODE_W-1:0]     mode_reg;
    logic [ROW_W-1:0]      row_reg;
    logic [CODE_W-1:0]     row_bits_reg;
    logic [DATA_W-1:0]     data_reg;
    logic [CODE_W-1:0]     rx_reg;
    logic [CODE_W-1:0]     emask_reg;

    // Output register.
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [CODE_W-1:0]     encoded_reg;
    logic [CODE_W-1:0]     encoded_next;
    logic [CODE_W-1:0]     corrected_reg;
    logic [CODE_W-1:0]     corrected_next;
    logic signed [POS_W-1:0] position_reg;
    logic signed [POS_W-1:0] position_next;
    logic [DATA_W-1:0]     decoded_reg;
    logic [DATA_W-1:0]     decoded_next;
    logic [SYN_W-1:0]      syndrome_reg;
    logic [SYN_W-1:0]      syndrome_next;

    logic                  advance;
    logic                  accept;
    logic                  s1_load;
    logic                  do_encode;
    logic                  do_decode;

    load_req_t             load_req;
    logic [CODE_BITS-1:0]  load_bits;
    logic [DATA_BITS-1:0]  data_ext;
    logic [CODE_BITS-1:0]  rx_ext;
    logic [CODE_BITS-1:0]  emask_ext;
    logic [CODE_BITS-1:0]  enc_cw;
    logic [CODE_BITS-1:0]  dec_in;
    logic [CODE_BITS-1:0]  dec_word;
    logic signed [POS_W-1:0] dec_pos;
    logic [DATA_BITS-1:0]  dec_data;
    logic [PARITY_BITS-1:0] dec_syn;

    logic [DATA_BITS-1:0][CODE_BITS-1:0]   gen_rows;
    logic [PARITY_BITS-1:0][CODE_BITS-1:0] chk_rows;
    logic [DATA_BITS-1:0][CODE_BITS-1:0]   rec_rows;

    // The input register moves on whenever the output register is free or being
    // emptied in the same cycle, so a held result does not block new requests until
    // both registers are occupied.
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg     <= mode;
            row_reg      <= row_index;
            row_bits_reg <= row_bits;
            data_reg     <= data_word;
            rx_reg       <= received_word;
            emask_reg    <= err_bits;
        end
    end

    // Fit the registered fields to the configured code and data widths.
    assign load_bits = CODE_BITS'(row_bits_reg[CW_MIN-1:0]);
    assign data_ext  = DATA_BITS'(data_reg[DW_MIN-1:0]);
    assign rx_ext    = CODE_BITS'(rx_reg[CW_MIN-1:0]);
    assign emask_ext = CODE_BITS'(emask_reg[CW_MIN-1:0]);

    assign s1_load   = (mode_reg == MODE_LOAD_GEN) || (mode_reg == MODE_LOAD_CHK) ||
                       (mode_reg == MODE_LOAD_REC);
    assign do_encode = (mode_reg == MODE_ENCODE) || (mode_reg == MODE_ROUND_TRIP);
    assign do_decode = (mode_reg == MODE_DECODE) || (mode_reg == MODE_ROUND_TRIP);

    // A load writes its row as it leaves the input register.
    always_comb
    begin
        load_req.gen_we = s1_valid_reg && advance && (mode_reg == MODE_LOAD_GEN);
        load_req.chk_we = s1_valid_reg && advance && (mode_reg == MODE_LOAD_CHK);
        load_req.rec_we = s1_valid_reg && advance && (mode_reg == MODE_LOAD_REC);
        load_req.row    = row_reg;
    end

    lsc_row_store #(
        .DATA_BITS   (DATA_BITS),
        .PARITY_BITS (PARITY_BITS),
        .CODE_BITS   (CODE_BITS)
    ) u_store (
        .clk       (clk),
        .load_req  (load_req),
        .load_bits (load_bits),
        .gen_rows  (gen_rows),
        .chk_rows  (chk_rows),
        .rec_rows  (rec_rows)
    );

    lsc_encode #(
        .DATA_BITS (DATA_BITS),
        .CODE_BITS (CODE_BITS)
    ) u_encode (
        .data     (data_ext),
        .gen_rows (gen_rows),
        .codeword (enc_cw)
    );

    // Round trip decodes the fresh codeword with the error mask applied; plain
    // decode takes the received word.
    assign dec_in = (mode_reg == MODE_ROUND_TRIP) ? (enc_cw ^ emask_ext) : rx_ext;

    lsc_decode #(
        .DATA_BITS   (DATA_BITS),
        .PARITY_BITS (PARITY_BITS),
        .CODE_BITS   (CODE_BITS)
    ) u_decode (
        .rx_word    (dec_in),
        .chk_rows   (chk_rows),
        .rec_rows   (rec_rows),
        .fixed_word (dec_word),
        .fixed_pos  (dec_pos),
        .data       (dec_data),
        .syn        (dec_syn)
    );

    // Fields that a mode does not produce are zero, including the position.
    always_comb
    begin
        encoded_next   = '0;
        corrected_next = '0;
        position_next  = '0;
        decoded_next   = '0;
        syndrome_next  = '0;
        if (do_encode)
        begin
            encoded_next = CODE_W'(enc_cw[CW_MIN-1:0]);
        end
        if (do_decode)
        begin
            corrected_next = CODE_W'(dec_word[CW_MIN-1:0]);
            position_next  = dec_pos;
            decoded_next   = DATA_W'(dec_data[DW_MIN-1:0]);
            syndrome_next  = SYN_W'(dec_syn);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            encoded_reg   <= encoded_next;
            corrected_reg <= corrected_next;
            position_reg  <= position_next;
            decoded_reg   <= decoded_next;
            syndrome_reg  <= syndrome_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign encoded_word       = encoded_reg;
    assign corrected_word     = corrected_reg;
    assign corrected_position = position_reg;
    assign decoded_data       = decoded_reg;
    assign syndrome           = syndrome_reg;

    // A request leaving the input register always lands in the output register.
    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && advance |=> out_valid_reg)
        else $error("request lost between input and output registers");

    // With the output register empty the block must be able to take a request.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with an empty output register");

    // A row load produces an all-zero result.
    a_load_zero: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && advance && s1_load |=>
            (encoded_reg == '0) && (corrected_reg == '0) && (syndrome_reg == '0) &&
            (decoded_reg == '0) && (position_reg == '0))
        else $error("row load gave a non-zero result");

endmodule

@@ rtl/core/lsc_row_store.sv @@
module lsc_row_store #(
    parameter int DATA_BITS   = 32,
    parameter int PARITY_BITS = 6,
    parameter int CODE_BITS   = 38
) (
    input  logic                                       clk,
    input  lsc_pkg::load_req_t                         load_req,
    input  logic [CODE_BITS-1:0]                       load_bits,
    output logic [DATA_BITS-1:0][CODE_BITS-1:0]        gen_rows,
    output logic [PARITY_BITS-1:0][CODE_BITS-1:0]      chk_rows,
    output logic [DATA_BITS-1:0][CODE_BITS-1:0]        rec_rows
);
    import lsc_pkg::*;

    logic [DATA_BITS-1:0][CODE_BITS-1:0]   gen_reg;
    logic [PARITY_BITS-1:0][CODE_BITS-1:0] chk_reg;
    logic [DATA_BITS-1:0][CODE_BITS-1:0]   rec_reg;

    // Contents are undefined until written, so the rows carry no reset.
    // A row number beyond a table's depth matches no entry and is dropped.
    always_ff @(posedge clk)
    begin
        for (int r = 0; r < DATA_BITS; r++)
        begin
            if (load_req.gen_we && (int'(load_req.row) == r))
            begin
                gen_reg[r] <= load_bits;
            end
            if (load_req.rec_we && (int'(load_req.row) == r))
            begin
                rec_reg[r] <= load_bits;
            end
        end
        for (int r = 0; r < PARITY_BITS; r++)
        begin
            if (load_req.chk_we && (int'(load_req.row) == r))
            begin
                chk_reg[r] <= load_bits;
            end
        end
    end

    assign gen_rows = gen_reg;
    assign chk_rows = chk_reg;
    assign rec_rows = rec_reg;

endmodule

@@ rtl/core/lsc_encode.sv @@
module lsc_encode #(
    parameter int DATA_BITS = 32,
    parameter int CODE_BITS = 38
) (
    input  logic [DATA_BITS-1:0]                data,
    input  logic [DATA_BITS-1:0][CODE_BITS-1:0] gen_rows,
    output logic [CODE_BITS-1:0]                codeword
);
    import lsc_pkg::*;

    // Each code bit is the parity of the data bits selected by its generator column.
    always_comb
    begin
        logic [DATA_BITS-1:0] col;
        for (int c = 0; c < CODE_BITS; c++)
        begin
            for (int k = 0; k < DATA_BITS; k++)
            begin
                col[k] = gen_rows[k][c];
            end
            codeword[c] = ^(data & col);
        end
    end

endmodule

@@ rtl/core/lsc_decode.sv @@
module lsc_decode #(
    parameter int DATA_BITS   = 32,
    parameter int PARITY_BITS = 6,
    parameter int CODE_BITS   = 38
) (
    input  logic [CODE_BITS-1:0]                  rx_word,
    input  logic [PARITY_BITS-1:0][CODE_BITS-1:0] chk_rows,
    input  logic [DATA_BITS-1:0][CODE_BITS-1:0]   rec_rows,
    output logic [CODE_BITS-1:0]                  fixed_word,
    output logic signed [lsc_pkg::POS_W-1:0]      fixed_pos,
    output logic [DATA_BITS-1:0]                  data,
    output logic [PARITY_BITS-1:0]                syn
);
    import lsc_pkg::*;

    logic [CODE_BITS-1:0] hit;
    logic [CODE_BITS-1:0] first_hit;
    logic [POS_W-1:0]     hit_idx;

    always_comb
    begin
        for (int i = 0; i < PARITY_BITS; i++)
        begin
            syn[i] = ^(rx_word & chk_rows[i]);
        end
    end

    // Compare every parity-check column against the syndrome in parallel.
    always_comb
    begin
        logic [PARITY_BITS-1:0] col;
        for (int c = 0; c < CODE_BITS; c++)
        begin
            for (int i = 0; i < PARITY_BITS; i++)
            begin
                col[i] = chk_rows[i][c];
            end
            hit[c] = (col == syn);
        end
    end

    // Isolate the lowest matching position and turn it into an index.
    assign first_hit = hit & (~hit + CODE_BITS'(1));

    always_comb
    begin
        hit_idx = '0;
        for (int c = 0; c < CODE_BITS; c++)
        begin
            if (first_hit[c])
            begin
                hit_idx = hit_idx | POS_W'(c);
            end
        end
    end

    assign fixed_word = rx_word ^ first_hit;
    assign fixed_pos  = (|hit) ? signed'(hit_idx) : '1;

    always_comb
    begin
        for (int k = 0; k < DATA_BITS; k++)
        begin
            data[k] = ^(fixed_word & rec_rows[k]);
        end
    end

endmodule
